### hw/rtl/si2rd_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer to radix digits: shared package
// Register map codes, character constants, state and control types.
// ----------------------------------------------------------------------------
package si2rd_pkg;

  localparam logic [1:0] REG_RADIX_SIZE   = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int RADIX_REG_W = 5;
  localparam int SYMBOL_COUNT = 16;
  localparam int DIV_STEP_BITS = 8;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } si2rd_state_t;

  typedef struct packed {
    logic load;
    logic start;
  } si2rd_div_cmd_t;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } si2rd_div_stat_t;

endpackage

### hw/rtl/si2rd_if.sv
// ----------------------------------------------------------------------------
// Signed integer to radix digits: stream interfaces
// Input value channel and output character channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface si2rd_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface si2rd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;

  modport source (output valid, output char_out, output last_char, input ready);
  modport sink (input valid, input char_out, input last_char, output ready);
endinterface

### hw/rtl/si2rd_divider.sv
// ----------------------------------------------------------------------------
// Signed integer to radix digits: iterative digit divider
// Divides the held magnitude by the radix, eight quotient bits per cycle,
// leaving the quotient in place and the remainder as the next digit.
// ----------------------------------------------------------------------------
module si2rd_divider #(
  parameter int VALUE_BITS  = 32,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  si2rd_pkg::si2rd_div_cmd_t         cmd,
  input  logic [VALUE_BITS-1:0]             load_value,
  input  logic [$clog2(MAX_SYMBOLS):0]      radix,
  output si2rd_pkg::si2rd_div_stat_t        stat,
  output logic [$clog2(MAX_SYMBOLS)-1:0]    digit
);

  localparam int STEP   = si2rd_pkg::DIV_STEP_BITS;
  localparam int DIG_W  = $clog2(MAX_SYMBOLS);
  localparam int NCHUNK = (VALUE_BITS + STEP - 1) / STEP;
  localparam int MAG_W  = NCHUNK * STEP;
  localparam int CNT_W  = $clog2(NCHUNK + 1);

  logic [MAG_W-1:0] mag_r;
  logic [DIG_W-1:0] rem_r;
  logic [CNT_W-1:0] chunk_r;
  logic             busy_r;
  logic             done_r;

  logic [DIG_W-1:0] rem_nxt;
  logic [STEP-1:0]  quot_bits;
  logic [STEP-1:0]  top_bits;
  logic             last_chunk;

  assign top_bits   = mag_r[MAG_W-1 -: STEP];
  assign last_chunk = (chunk_r == CNT_W'(NCHUNK - 1));

  always_comb begin
    logic [DIG_W:0] trial;
    rem_nxt   = rem_r;
    quot_bits = '0;
    for (int k = STEP - 1; k >= 0; k--) begin
      trial = {rem_nxt, top_bits[k]};
      if (trial >= radix) begin
        quot_bits[k] = 1'b1;
        trial        = trial - radix;
      end
      rem_nxt = trial[DIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last_chunk;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_chunk) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= MAG_W'(load_value);
    end else if (busy_r) begin
      mag_r <= (mag_r << STEP) | MAG_W'(quot_bits);
    end
    if (cmd.start) begin
      rem_r   <= '0;
      chunk_r <= '0;
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      chunk_r <= chunk_r + CNT_W'(1);
    end
  end

  assign stat.done      = done_r;
  assign stat.quot_zero = (mag_r == '0);
  assign digit          = rem_r;

endmodule

### hw/rtl/signed_integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// Signed integer to radix digits: top level
// Converts a signed integer into its text in a configurable radix.
// ----------------------------------------------------------------------------
// Each accepted value is written out as a '-' byte when negative, then one
// alphabet symbol per digit, most significant first, with last_char set on
// the final byte. Nothing is emitted while the alphabet is invalid, which
// includes the state after reset, and such a value is accepted and dropped.
// The input is not ready while a value is being converted. For each digit
// the divider yields eight quotient bits per cycle and then hands the digit
// over to a stack; the stored digits are sent once the quotient is zero,
// and output stalls hold the sending back.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits #(
  parameter int VALUE_BITS  = 32,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  si2rd_in_if.sink                            in_chan,
  si2rd_out_if.source                         out_chan,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [si2rd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [si2rd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [si2rd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int DIG_W = $clog2(MAX_SYMBOLS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int RAD_W = si2rd_pkg::RADIX_REG_W;

  logic [RAD_W-1:0]  radix_size_r;
  logic [63:0]       symbols_low_r;
  logic [63:0]       symbols_high_r;
  logic              alphabet_ok_r;
  logic              alphabet_ok;
  logic [si2rd_pkg::SYMBOL_COUNT-1:0][7:0] sym_tab;

  si2rd_pkg::si2rd_state_t state_r, state_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIG_W-1:0]  stack_r [VALUE_BITS];
  logic              push, pop;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free;

  logic              in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  si2rd_pkg::si2rd_div_cmd_t  div_cmd;
  si2rd_pkg::si2rd_div_stat_t div_stat;
  logic [DIG_W-1:0]           div_digit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_size_r   <= '0;
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        si2rd_pkg::REG_RADIX_SIZE:   radix_size_r   <= pwdata[RAD_W-1:0];
        si2rd_pkg::REG_SYMBOLS_LOW:  symbols_low_r  <= pwdata;
        si2rd_pkg::REG_SYMBOLS_HIGH: symbols_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      si2rd_pkg::REG_RADIX_SIZE:   prdata = 64'(radix_size_r);
      si2rd_pkg::REG_SYMBOLS_LOW:  prdata = symbols_low_r;
      si2rd_pkg::REG_SYMBOLS_HIGH: prdata = symbols_high_r;
      default:                     prdata = '0;
    endcase
  end

  assign pready  = 1'b1;
  assign sym_tab = {symbols_high_r, symbols_low_r};

  // Alphabet check, registered behind the configuration registers.
  always_comb begin
    alphabet_ok = (radix_size_r >= RAD_W'(2)) && (radix_size_r <= RAD_W'(MAX_SYMBOLS));
    for (int i = 0; i < si2rd_pkg::SYMBOL_COUNT; i++) begin
      if (RAD_W'(i) < radix_size_r) begin
        if (sym_tab[i] == si2rd_pkg::CHAR_PLUS || sym_tab[i] == si2rd_pkg::CHAR_MINUS) begin
          alphabet_ok = 1'b0;
        end
      end
      for (int j = i + 1; j < si2rd_pkg::SYMBOL_COUNT; j++) begin
        if ((RAD_W'(j) < radix_size_r) && (sym_tab[i] == sym_tab[j])) begin
          alphabet_ok = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alphabet_ok_r <= 1'b0;
    end else begin
      alphabet_ok_r <= alphabet_ok;
    end
  end

  assign in_neg = in_chan.value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~$unsigned(in_chan.value) + VALUE_BITS'(1))
                         : $unsigned(in_chan.value);

  si2rd_divider #(
    .VALUE_BITS  (VALUE_BITS),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (div_cmd),
    .load_value (in_mag),
    .radix      (radix_size_r[DIG_W:0]),
    .stat       (div_stat),
    .digit      (div_digit)
  );

  assign in_chan.ready = (state_r == si2rd_pkg::ST_IDLE);
  assign slot_free     = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= si2rd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (push) begin
      stack_r[0] <= div_digit;
      for (int k = 1; k < VALUE_BITS; k++) begin
        stack_r[k] <= stack_r[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < VALUE_BITS - 1; k++) begin
        stack_r[k] <= stack_r[k+1];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    push          = 1'b0;
    pop           = 1'b0;
    div_cmd       = '0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      si2rd_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          div_cmd.load = 1'b1;
          neg_nxt      = in_neg;
          cnt_nxt      = '0;
          state_nxt    = si2rd_pkg::ST_CHECK;
        end
      end
      si2rd_pkg::ST_CHECK: begin
        if (alphabet_ok_r) begin
          div_cmd.start = 1'b1;
          state_nxt     = si2rd_pkg::ST_DIV;
        end else begin
          state_nxt = si2rd_pkg::ST_IDLE;
        end
      end
      si2rd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          push    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (div_stat.quot_zero) begin
            state_nxt = si2rd_pkg::ST_EMIT;
          end else begin
            div_cmd.start = 1'b1;
          end
        end
      end
      si2rd_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            neg_nxt      = 1'b0;
            out_char_nxt = si2rd_pkg::CHAR_MINUS;
            out_last_nxt = 1'b0;
          end else begin
            pop          = 1'b1;
            cnt_nxt      = cnt_r - CNT_W'(1);
            out_char_nxt = sym_tab[4'(stack_r[0])];
            out_last_nxt = (cnt_r == CNT_W'(1));
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = si2rd_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = si2rd_pkg::ST_IDLE;
    endcase
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.char_out  = out_char_r;
  assign out_chan.last_char = out_last_r;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Signed integer to radix digits: testbench
// Drives values through the stream input, writes the alphabet and radix over
// the register port, and checks every output byte against expected text that
// is typed in or predicted. A directed table covers reset, extremes and broken
// alphabets, then random phases run through many alphabets with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 22;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } text_byte_t;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         reg_idx;
    logic [63:0]        data;
    logic signed [31:0] value;
    bit                 typed;
    string              text;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [si2rd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [si2rd_pkg::CFG_DATA_W-1:0] pwdata;
  logic [si2rd_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  si2rd_in_if #(.VALUE_BITS(32)) in_if ();
  si2rd_out_if out_if ();

  signed_integer_to_radix_digits #(
    .VALUE_BITS (32),
    .MAX_SYMBOLS(16)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [4:0]  shadow_radix;
  logic [63:0] shadow_sym_lo;
  logic [63:0] shadow_sym_hi;

  text_byte_t pending_chars[$];
  stim_row_t  directed_rows[$];
  int  fail_count;
  int  stall_cycles;
  int  burst_left;
  bit  quiet;
  bit  hold_req;
  int  hold_left;
  int  mode_left;
  int  rx_mode;
  int  pat_cnt;

  always #5 clk = ~clk;

  function automatic logic [7:0] symbol_of(input int idx);
    if (idx < 8) return shadow_sym_lo[8*idx +: 8];
    return shadow_sym_hi[8*(idx-8) +: 8];
  endfunction

  function automatic bit alphabet_usable();
    int n;
    n = shadow_radix;
    if (n < 2 || n > 16) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (symbol_of(i) == si2rd_pkg::CHAR_PLUS || symbol_of(i) == si2rd_pkg::CHAR_MINUS)
        return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (symbol_of(j) == symbol_of(i)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_digits(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [7:0]  digits[$];
    if (!alphabet_usable()) return;
    radix = shadow_radix;
    mag   = v[31] ? (~v + 32'd1) : v;
    do begin
      digits.push_back(symbol_of(int'(mag % radix)));
      mag = mag / radix;
    end while (mag != 0);
    if (v[31]) pending_chars.push_back('{si2rd_pkg::CHAR_MINUS, 1'b0});
    for (int i = digits.size() - 1; i >= 0; i--) begin
      pending_chars.push_back('{digits[i], i == 0});
    end
  endfunction

  function automatic logic [127:0] random_alphabet(input int n, input bit extremes);
    logic [127:0] syms;
    bit   [255:0] taken;
    int           b;
    taken = '0;
    taken[si2rd_pkg::CHAR_PLUS]  = 1'b1;
    taken[si2rd_pkg::CHAR_MINUS] = 1'b1;
    if (extremes) begin
      taken[8'h00] = 1'b1;
      taken[8'hFF] = 1'b1;
    end
    syms = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      if (extremes && i == 0) begin
        syms[7:0] = 8'h00;
      end else if (extremes && i == n - 1) begin
        syms[8*i +: 8] = 8'hFF;
      end else begin
        do b = $urandom_range(0, 255); while (taken[b]);
        taken[b] = 1'b1;
        syms[8*i +: 8] = b[7:0];
      end
    end
    return syms;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [63:0] data);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.data = data;
    r.value = '0;
    r.typed = 1'b0;
    r.text = "";
    return r;
  endfunction

  function automatic stim_row_t val_row(input logic signed [31:0] v, input bit typed,
                                        input string text);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = si2rd_pkg::REG_RADIX_SIZE;
    r.data = '0;
    r.value = v;
    r.typed = typed;
    r.text = text;
    return r;
  endfunction

  task automatic stop_input();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic drain_results();
    stop_input();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic send_value(input logic signed [31:0] v, input bit typed, input string text);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.value = v;
    do @(posedge clk); while (!in_if.ready);
    quiet = 1'b0;
    burst_left--;
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        pending_chars.push_back('{text[i], i == text.len() - 1});
      end
    end else begin
      predict_digits(v);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    if (!quiet) begin
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clk);
      quiet = 1'b1;
    end
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      si2rd_pkg::REG_RADIX_SIZE:   shadow_radix  = data[4:0];
      si2rd_pkg::REG_SYMBOLS_LOW:  shadow_sym_lo = data;
      si2rd_pkg::REG_SYMBOLS_HIGH: shadow_sym_hi = data;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Output-side acceptance: long hold-offs on request, otherwise a changing pattern.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_if.ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(30, 200);
      end
      mode_left--;
      pat_cnt++;
      case (rx_mode)
        0:       out_if.ready = 1'b1;
        1:       out_if.ready = $urandom_range(0, 1);
        2:       out_if.ready = (pat_cnt % 4 == 0);
        default: out_if.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    text_byte_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        $error("char_out: expected none, got 0x%02h (last_char %0b)",
               out_if.char_out, out_if.last_char);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_if.char_out !== want.char_code) begin
          $error("char_out: expected 0x%02h, got 0x%02h", want.char_code, out_if.char_out);
          fail_count++;
        end
        if (out_if.last_char !== want.last) begin
          $error("last_char: expected %0b, got %0b", want.last, out_if.last_char);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int               n;
    int               j;
    logic [127:0]     syms;
    logic signed [31:0] v;
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    shadow_radix = '0;
    shadow_sym_lo = '0;
    shadow_sym_hi = '0;
    fail_count = 0;
    stall_cycles = 0;
    burst_left = 0;
    quiet = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    mode_left = 0;
    rx_mode = 0;
    pat_cnt = 0;

    // After reset the alphabet is empty, so nothing comes out.
    directed_rows.push_back(val_row(32'sd5, 1'b1, ""));
    directed_rows.push_back(val_row(32'sh8000_0000, 1'b1, ""));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd10));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_HIGH, 64'h0000_0000_0000_3938));
    directed_rows.push_back(val_row(32'sd0, 1'b1, "0"));
    directed_rows.push_back(val_row(-32'sd1, 1'b1, "-1"));
    directed_rows.push_back(val_row(32'sh7FFF_FFFF, 1'b1, "2147483647"));
    directed_rows.push_back(val_row(32'sh8000_0000, 1'b1, "-2147483648"));
    directed_rows.push_back(val_row(32'sd1000, 1'b1, "1000"));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd2));
    directed_rows.push_back(val_row(32'sh8000_0000, 1'b0, ""));
    directed_rows.push_back(val_row(-32'sd1, 1'b1, "-1"));
    directed_rows.push_back(val_row(32'sh7FFF_FFFF, 1'b0, ""));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd16));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_HIGH, 64'h4645_4443_4241_3938));
    directed_rows.push_back(val_row(32'sh7FFF_FFFF, 1'b1, "7FFFFFFF"));
    directed_rows.push_back(val_row(32'shDEAD_BEEF, 1'b0, ""));
    directed_rows.push_back(val_row(32'sh8000_0000, 1'b1, "-80000000"));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd17));
    directed_rows.push_back(val_row(32'sd1, 1'b1, ""));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd31));
    directed_rows.push_back(val_row(32'sd1, 1'b1, ""));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd1));
    directed_rows.push_back(val_row(32'sd1, 1'b1, ""));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd0));
    directed_rows.push_back(val_row(32'sd1, 1'b1, ""));
    // A sign character among the symbols in use disables output.
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd16));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_HIGH, 64'h2D45_4443_4241_3938));
    directed_rows.push_back(val_row(32'sd7, 1'b1, ""));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_HIGH, 64'h4645_4443_4241_3938));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_LOW, 64'h3736_3534_3332_312B));
    directed_rows.push_back(val_row(32'sd7, 1'b1, ""));
    // Repeated symbol, then the same bytes with the repeat left unused.
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_HIGH, 64'h4645_4443_4241_3930));
    directed_rows.push_back(val_row(32'sd7, 1'b1, ""));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd8));
    directed_rows.push_back(val_row(32'sd8, 1'b1, "10"));
    directed_rows.push_back(val_row(-32'sd9, 1'b1, "-11"));
    // Zero and all-ones bytes as symbols, with sign bytes beyond the radix.
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_RADIX_SIZE, 64'd2));
    directed_rows.push_back(cfg_row(si2rd_pkg::REG_SYMBOLS_LOW, 64'h2D2B_2D2B_2D2B_FF00));
    directed_rows.push_back(val_row(32'sd6, 1'b0, ""));
    directed_rows.push_back(val_row(-32'sd1, 1'b0, ""));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) begin
        write_reg(directed_rows[k].reg_idx, directed_rows[k].data);
      end else begin
        send_value(directed_rows[k].value, directed_rows[k].typed, directed_rows[k].text);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph % 3 == 1) begin
        n = $urandom_range(2, 16);
        syms = random_alphabet(n, 1'b0);
        case ($urandom_range(0, 3))
          0: n = $urandom_range(0, 1);
          1: n = $urandom_range(17, 31);
          2: syms[8*$urandom_range(0, n - 1) +: 8] =
               $urandom_range(0, 1) ? si2rd_pkg::CHAR_PLUS : si2rd_pkg::CHAR_MINUS;
          default: begin
            j = $urandom_range(1, n - 1);
            syms[8*j +: 8] = syms[8*$urandom_range(0, j - 1) +: 8];
          end
        endcase
        write_reg(si2rd_pkg::REG_SYMBOLS_LOW, syms[63:0]);
        write_reg(si2rd_pkg::REG_SYMBOLS_HIGH, syms[127:64]);
        write_reg(si2rd_pkg::REG_RADIX_SIZE, 64'(n));
        repeat (4) send_value($urandom, 1'b0, "");
      end
      n = (ph == 0) ? 2 : (ph == PHASES - 1) ? 16 : $urandom_range(2, 16);
      syms = random_alphabet(n, ph == 1 || ph == PHASES - 1);
      write_reg(si2rd_pkg::REG_SYMBOLS_LOW, syms[63:0]);
      write_reg(si2rd_pkg::REG_SYMBOLS_HIGH, syms[127:64]);
      write_reg(si2rd_pkg::REG_RADIX_SIZE, 64'(n));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 8) hold_req = 1'b1;
        if (ph == 5 && k == 12) drain_results();
        case ($urandom_range(0, 5))
          0, 1: v = $urandom;
          2: begin
            v = $urandom_range(0, 40);
            if ($urandom_range(0, 1)) v = -v;
          end
          3: begin
            case ($urandom_range(0, 4))
              0:       v = 32'sh8000_0000;
              1:       v = 32'sh7FFF_FFFF;
              2:       v = 32'sd0;
              3:       v = -32'sd1;
              default: v = 32'sd1;
            endcase
          end
          4: begin
            v = 32'sd1 <<< $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = -v;
          end
          default: v = $signed($urandom) >>> $urandom_range(0, 31);
        endcase
        send_value(v, 1'b0, "");
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/si2rd_pkg.sv
hw/rtl/si2rd_if.sv
hw/rtl/si2rd_divider.sv
hw/rtl/signed_integer_to_radix_digits.sv
tb/tb_top.sv
